/* src/rpf_pkg.sv */
`default_nettype none

package rpf_pkg;

  localparam int unsigned MaxPayloadDflt = 64;
  localparam int unsigned HdrLen         = 6;
  localparam int unsigned FrameOverhead  = 10;
  localparam int unsigned NumBanks       = 4;
  localparam int unsigned TailLen        = 4;
  localparam int unsigned RxEndOffset    = 3;
  localparam int unsigned TxEndOffset    = 9;

  localparam logic [7:0] SyncByte  = 8'hAA;
  localparam logic [7:0] SyncWordH = 8'h2D;
  localparam logic [7:0] SyncWordL = 8'hD4;
  localparam logic [7:0] PadByte   = 8'h00;

  typedef enum logic [2:0] {
    ActEvent     = 3'd0,
    ActRxStart   = 3'd1,
    ActRxTake    = 3'd2,
    ActRxRead    = 3'd3,
    ActTxBegin   = 3'd4,
    ActTxPayload = 3'd5,
    ActStop      = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StUnread   = 3'd1,
    StTxActive = 3'd2,
    StRxActive = 3'd3,
    StNotReady = 3'd4,
    StTooLong  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] count_or_position;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] received_length;
    logic       packet_ready;
    logic       tx_busy;
    logic       rx_busy;
    logic       is_send;
    logic       is_read;
    logic       use_store;
    logic [7:0] hdr_byte;
  } result_t;

endpackage

`default_nettype wire

/* src/rpf_item_if.sv */
`default_nettype none

interface rpf_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data_byte;
  logic [7:0] count_or_position;

  modport source (output valid, action, data_byte, count_or_position, input ready);
  modport sink   (input valid, action, data_byte, count_or_position, output ready);
endinterface

`default_nettype wire

/* src/rpf_result_if.sv */
`default_nettype none

interface rpf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] send_byte;
  logic       send_valid;
  logic [2:0] status;
  logic [6:0] received_length;
  logic [7:0] read_byte;
  logic       packet_ready;
  logic       tx_busy;
  logic       rx_busy;

  modport source (
    output valid, send_byte, send_valid, status, received_length, read_byte,
           packet_ready, tx_busy, rx_busy,
    input  ready
  );
  modport sink (
    input  valid, send_byte, send_valid, status, received_length, read_byte,
           packet_ready, tx_busy, rx_busy,
    output ready
  );
endinterface

`default_nettype wire

/* src/rpf_ram.sv */
`default_nettype none

module rpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/rpf_store.sv */
`default_nettype none

module rpf_store #(
  parameter int unsigned MaxPayload = rpf_pkg::MaxPayloadDflt,
  localparam int unsigned StoreDepth = MaxPayload + rpf_pkg::FrameOverhead,
  localparam int unsigned AddrW = $clog2(StoreDepth),
  localparam int unsigned RowW = AddrW - 2,
  localparam int unsigned NumRows = (StoreDepth + rpf_pkg::NumBanks - 1) / rpf_pkg::NumBanks
) (
  input  wire logic                                      clk_i,
  input  wire logic [rpf_pkg::NumBanks-1:0]              wr_en_i,
  input  wire logic [rpf_pkg::NumBanks-1:0][RowW-1:0]    wr_row_i,
  input  wire logic [rpf_pkg::NumBanks-1:0][7:0]         wr_data_i,
  input  wire logic                                      rd_en_i,
  input  wire logic [AddrW-1:0]                          rd_addr_i,
  output logic      [7:0]                                rd_data_o
);

  import rpf_pkg::*;

  logic [NumBanks-1:0][7:0] bank_data;
  logic [1:0]               bank_q;

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    rpf_ram #(
      .Width (8),
      .Depth (NumRows)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en_i[b]),
      .waddr_i (wr_row_i[b]),
      .wdata_i (wr_data_i[b]),
      .re_i    (rd_en_i),
      .raddr_i (rd_addr_i[AddrW-1:2]),
      .rdata_o (bank_data[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      bank_q <= rd_addr_i[1:0];
    end
  end

  assign rd_data_o = bank_data[bank_q];

endmodule

`default_nettype wire

/* src/rpf_ctrl.sv */
`default_nettype none

module rpf_ctrl #(
  parameter int unsigned MaxPayload = rpf_pkg::MaxPayloadDflt,
  localparam int unsigned StoreDepth = MaxPayload + rpf_pkg::FrameOverhead,
  localparam int unsigned AddrW = $clog2(StoreDepth),
  localparam int unsigned RowW = AddrW - 2,
  localparam int unsigned CntW = $clog2(MaxPayload + 1)
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      advance_i,
  input  wire rpf_pkg::item_t                            item_i,
  output rpf_pkg::result_t                               result_o,
  output logic      [rpf_pkg::NumBanks-1:0]              wr_en_o,
  output logic      [rpf_pkg::NumBanks-1:0][RowW-1:0]    wr_row_o,
  output logic      [rpf_pkg::NumBanks-1:0][7:0]         wr_data_o,
  output logic                                           rd_en_o,
  output logic      [AddrW-1:0]                          rd_addr_o
);

  import rpf_pkg::*;

  logic [AddrW-1:0]           pos_q, pos_d;
  logic [CntW-1:0]            load_q, load_d;
  logic                       rx_q, rx_d;
  logic                       tx_q, tx_d;
  logic                       rdy_q, rdy_d;
  logic [HdrLen-1:0][7:0]     hdr_q, hdr_d;

  always_comb begin
    action_e          act;
    logic [7:0]       data;
    logic [7:0]       arg;
    logic [7:0]       wbyte;
    logic [7:0]       hdr0_new;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] tail_addr;

    act       = action_e'(item_i.action);
    data      = item_i.data_byte;
    arg       = item_i.count_or_position;
    wbyte     = data;
    hdr0_new  = hdr_q[0];
    waddr     = '0;
    tail_addr = '0;

    pos_d  = pos_q;
    load_d = load_q;
    rx_d   = rx_q;
    tx_d   = tx_q;
    rdy_d  = rdy_q;
    hdr_d  = hdr_q;

    wr_en_o   = '0;
    wr_row_o  = '0;
    wr_data_o = '0;
    rd_en_o   = advance_i;
    rd_addr_o = pos_q;

    result_o        = '0;
    result_o.status = StOk;

    case (act)
      ActEvent: begin
        if (rx_q) begin
          if (pos_q < AddrW'(MaxPayload)) begin
            if (pos_q == '0 && data > 8'(MaxPayload)) begin
              wbyte = 8'(MaxPayload);
            end
            if (pos_q == '0) begin
              hdr0_new = wbyte;
            end
            if (pos_q < AddrW'(HdrLen)) begin
              hdr_d[pos_q[2:0]] = wbyte;
            end else begin
              wr_en_o[pos_q[1:0]]   = 1'b1;
              wr_row_o[pos_q[1:0]]  = pos_q[AddrW-1:2];
              wr_data_o[pos_q[1:0]] = wbyte;
            end
            pos_d = pos_q + AddrW'(1);
          end else begin
            rx_d = 1'b0;
          end
          if (9'(pos_d) >= 9'(hdr0_new) + 9'(RxEndOffset)) begin
            rx_d  = 1'b0;
            rdy_d = 1'b1;
          end
        end else if (tx_q) begin
          result_o.is_send = 1'b1;
          if (9'(pos_q) >= 9'(hdr_q[5]) + 9'(TxEndOffset)) begin
            tx_d = 1'b0;
          end else begin
            pos_d = pos_q + AddrW'(1);
          end
        end
      end
      ActRxStart: begin
        if (rdy_q) begin
          result_o.status = StUnread;
        end else if (tx_q) begin
          result_o.status = StTxActive;
        end else if (rx_q) begin
          result_o.status = StRxActive;
        end else begin
          pos_d = '0;
          rx_d  = 1'b1;
        end
      end
      ActRxTake: begin
        if (rx_q || !rdy_q) begin
          result_o.status = StNotReady;
        end else begin
          rdy_d                    = 1'b0;
          result_o.received_length = hdr_q[0][6:0];
        end
      end
      ActRxRead: begin
        if (arg < 8'(MaxPayload)) begin
          result_o.is_read = 1'b1;
          rd_addr_o        = AddrW'(arg) + AddrW'(1);
        end
      end
      ActTxBegin: begin
        rx_d   = 1'b0;
        tx_d   = 1'b0;
        rdy_d  = 1'b0;
        load_d = '0;
        if (arg > 8'(MaxPayload)) begin
          result_o.status = StTooLong;
        end else begin
          hdr_d[0] = SyncByte;
          hdr_d[1] = SyncByte;
          hdr_d[2] = SyncByte;
          hdr_d[3] = SyncWordH;
          hdr_d[4] = SyncWordL;
          hdr_d[5] = arg;
          for (int k = 0; k < TailLen; k++) begin
            tail_addr = AddrW'(arg) + AddrW'(HdrLen) + AddrW'(k);
            wr_en_o[tail_addr[1:0]]   = 1'b1;
            wr_row_o[tail_addr[1:0]]  = tail_addr[AddrW-1:2];
            wr_data_o[tail_addr[1:0]] = (k < 2) ? PadByte : SyncByte;
          end
          pos_d = '0;
          tx_d  = 1'b1;
        end
      end
      ActTxPayload: begin
        if (tx_q && 8'(load_q) < hdr_q[5]) begin
          waddr                 = AddrW'(load_q) + AddrW'(HdrLen);
          wr_en_o[waddr[1:0]]   = 1'b1;
          wr_row_o[waddr[1:0]]  = waddr[AddrW-1:2];
          wr_data_o[waddr[1:0]] = data;
          load_d                = load_q + CntW'(1);
        end else begin
          result_o.status = StNotReady;
        end
      end
      ActStop: begin
        rx_d  = 1'b0;
        tx_d  = 1'b0;
        rdy_d = 1'b0;
      end
      default: begin
      end
    endcase

    if (!advance_i) begin
      wr_en_o = '0;
    end

    result_o.use_store    = (rd_addr_o >= AddrW'(HdrLen));
    result_o.hdr_byte     = result_o.use_store ? 8'h00 : hdr_q[rd_addr_o[2:0]];
    result_o.packet_ready = rdy_d;
    result_o.tx_busy      = tx_d;
    result_o.rx_busy      = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      load_q <= '0;
      rx_q   <= 1'b0;
      tx_q   <= 1'b0;
      rdy_q  <= 1'b0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      load_q <= load_d;
      rx_q   <= rx_d;
      tx_q   <= tx_d;
      rdy_q  <= rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      hdr_q <= hdr_d;
    end
  end

endmodule

`default_nettype wire

/* src/radio_packet_framer_top.sv */
// An accepted input beat is registered in item_q and its result in res_q.
// Throughput: one beat per cycle while output is ready; the frame store takes
// one read and one write per bank each cycle, and the four banks absorb the
// frame tail of a tx_begin. Output back-pressure stalls both stages; input
// ready follows output ready. Reset clears the flags, the position and the
// load count; the frame store keeps its contents and needs no clearing pass.
`default_nettype none

module radio_packet_framer_top #(
  parameter int unsigned MaxPayload = rpf_pkg::MaxPayloadDflt,
  localparam int unsigned StoreDepth = MaxPayload + rpf_pkg::FrameOverhead,
  localparam int unsigned AddrW = $clog2(StoreDepth),
  localparam int unsigned RowW = AddrW - 2
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rpf_item_if.sink  req_i,
  rpf_result_if.source rsp_o
);

  import rpf_pkg::*;

  logic    s1_valid_q;
  item_t   item_q;
  logic    s2_valid_q;
  result_t res_q;
  result_t res;
  logic    advance;
  logic    accept;

  logic [NumBanks-1:0]           wr_en;
  logic [NumBanks-1:0][RowW-1:0] wr_row;
  logic [NumBanks-1:0][7:0]      wr_data;
  logic                          rd_en;
  logic [AddrW-1:0]              rd_addr;
  logic [7:0]                    store_byte;
  logic [7:0]                    frame_byte;

  assign advance     = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !advance);
      s2_valid_q <= advance || (s2_valid_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action            <= req_i.action;
      item_q.data_byte         <= req_i.data_byte;
      item_q.count_or_position <= req_i.count_or_position;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  rpf_ctrl #(
    .MaxPayload (MaxPayload)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (res),
    .wr_en_o   (wr_en),
    .wr_row_o  (wr_row),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  rpf_store #(
    .MaxPayload (MaxPayload)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (store_byte)
  );

  assign frame_byte = res_q.use_store ? store_byte : res_q.hdr_byte;

  assign rsp_o.valid           = s2_valid_q;
  assign rsp_o.send_byte       = res_q.is_send ? frame_byte : 8'h00;
  assign rsp_o.send_valid      = res_q.is_send;
  assign rsp_o.status          = res_q.status;
  assign rsp_o.received_length = res_q.received_length;
  assign rsp_o.read_byte       = res_q.is_read ? frame_byte : 8'h00;
  assign rsp_o.packet_ready    = res_q.packet_ready;
  assign rsp_o.tx_busy         = res_q.tx_busy;
  assign rsp_o.rx_busy         = res_q.rx_busy;

endmodule

`default_nettype wire

/* src/rpf_checker.sv */
`default_nettype none

module rpf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       rsp_valid_i,
  input wire logic       rsp_ready_i,
  input wire logic       send_valid_i,
  input wire logic [7:0] send_byte_i,
  input wire logic [2:0] status_i,
  input wire logic [6:0] received_length_i,
  input wire logic [7:0] read_byte_i,
  input wire logic       packet_ready_i,
  input wire logic       tx_busy_i,
  input wire logic       rx_busy_i
);

  import rpf_pkg::*;

  a_busy_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(tx_busy_i && rx_busy_i))
    else $error("Transmit and receive are both active.");

  a_send_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && send_valid_i) |->
      (status_i == StOk && read_byte_i == 8'h00 && received_length_i == 7'd0))
    else $error("A transmit beat carries fields of another action.");

  a_too_long_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == StTooLong) |->
      (!tx_busy_i && !rx_busy_i && !packet_ready_i && !send_valid_i))
    else $error("A rejected transmit left activity running.");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && received_length_i != 7'd0) |->
      (status_i == StOk && !packet_ready_i && !rx_busy_i))
    else $error("A taken packet is still marked ready.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(send_byte_i) && $stable(status_i) && $stable(read_byte_i)))
    else $error("A stalled result beat changed.");

endmodule

bind radio_packet_framer_top rpf_checker u_rpf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .send_valid_i      (rsp_o.send_valid),
  .send_byte_i       (rsp_o.send_byte),
  .status_i          (rsp_o.status),
  .received_length_i (rsp_o.received_length),
  .read_byte_i       (rsp_o.read_byte),
  .packet_ready_i    (rsp_o.packet_ready),
  .tx_busy_i         (rsp_o.tx_busy),
  .rx_busy_i         (rsp_o.rx_busy)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rpf_pkg::*;

  localparam int unsigned MaxPay = MaxPayloadDflt;
  localparam int unsigned MemDepth = MaxPay + FrameOverhead;
  localparam logic [2:0] ActUnused = 3'd7;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic [2:0] status;
    logic [6:0] received_length;
    logic [7:0] read_byte;
    logic       packet_ready;
    logic       tx_busy;
    logic       rx_busy;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rpf_item_if req_if ();
  rpf_result_if rsp_if ();

  radio_packet_framer_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0] frame_mem [MemDepth];
  logic [MemDepth-1:0] mem_written = '0;
  int unsigned frame_pos = 0;
  int unsigned load_cnt = 0;
  bit rx_active = 1'b0;
  bit tx_active = 1'b0;
  bit pkt_waiting = 1'b0;

  frame_result_t expected_results [$];
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  function automatic void mem_put(int unsigned addr, logic [7:0] value);
    frame_mem[addr] = value;
    mem_written[addr] = 1'b1;
  endfunction

  function automatic frame_result_t framer_predict(logic [2:0] act, logic [7:0] data,
                                                   logic [7:0] arg);
    frame_result_t r;
    r = '0;
    case (act)
      ActEvent: begin
        if (rx_active) begin
          if (frame_pos < MaxPay) begin
            if (frame_pos == 0 && data > MaxPay) data = 8'(MaxPay);
            mem_put(frame_pos, data);
            frame_pos++;
          end else begin
            rx_active = 1'b0;
          end
          if (frame_pos >= int'(frame_mem[0]) + RxEndOffset) begin
            rx_active = 1'b0;
            pkt_waiting = 1'b1;
          end
        end else if (tx_active) begin
          r.send_byte = frame_mem[frame_pos];
          r.send_valid = 1'b1;
          if (frame_pos >= int'(frame_mem[5]) + TxEndOffset) tx_active = 1'b0;
          else frame_pos++;
        end
      end
      ActRxStart: begin
        if (pkt_waiting) r.status = StUnread;
        else if (tx_active) r.status = StTxActive;
        else if (rx_active) r.status = StRxActive;
        else begin
          frame_pos = 0;
          rx_active = 1'b1;
        end
      end
      ActRxTake: begin
        if (rx_active || !pkt_waiting) begin
          r.status = StNotReady;
        end else begin
          pkt_waiting = 1'b0;
          r.received_length = frame_mem[0][6:0];
        end
      end
      ActRxRead: begin
        if (arg < MaxPay) r.read_byte = frame_mem[arg + 1];
      end
      ActTxBegin: begin
        rx_active = 1'b0;
        tx_active = 1'b0;
        pkt_waiting = 1'b0;
        load_cnt = 0;
        if (arg > MaxPay) begin
          r.status = StTooLong;
        end else begin
          mem_put(0, SyncByte);
          mem_put(1, SyncByte);
          mem_put(2, SyncByte);
          mem_put(3, SyncWordH);
          mem_put(4, SyncWordL);
          mem_put(5, arg);
          mem_put(arg + 6, PadByte);
          mem_put(arg + 7, PadByte);
          mem_put(arg + 8, SyncByte);
          mem_put(arg + 9, SyncByte);
          frame_pos = 0;
          tx_active = 1'b1;
        end
      end
      ActTxPayload: begin
        if (tx_active && load_cnt < frame_mem[5]) begin
          mem_put(HdrLen + load_cnt, data);
          load_cnt++;
        end else begin
          r.status = StNotReady;
        end
      end
      ActStop: begin
        rx_active = 1'b0;
        tx_active = 1'b0;
        pkt_waiting = 1'b0;
      end
      default: ;
    endcase
    r.packet_ready = pkt_waiting;
    r.tx_busy = tx_active;
    r.rx_busy = rx_active;
    return r;
  endfunction

  // The frame store powers up with unknown contents, so a beat that would read an
  // entry not yet written since reset is dropped instead of sent.
  function automatic bit reads_unwritten(logic [2:0] act, logic [7:0] arg);
    if (act == ActEvent && !rx_active && tx_active) return !mem_written[frame_pos];
    if (act == ActRxRead && arg < MaxPay) return !mem_written[arg + 1];
    return 1'b0;
  endfunction

  function automatic string result_text(frame_result_t r);
    return $sformatf("send=%h/%b status=%0d len=%0d read=%h ready=%b tx=%b rx=%b",
                     r.send_byte, r.send_valid, r.status, r.received_length,
                     r.read_byte, r.packet_ready, r.tx_busy, r.rx_busy);
  endfunction

  task automatic send_item(input logic [2:0] act, input logic [7:0] data,
                           input logic [7:0] arg);
    if (reads_unwritten(act, arg)) return;
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.data_byte <= data;
    req_if.count_or_position <= arg;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_results.push_back(framer_predict(act, data, arg));
    beats_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) hold_cycles--;
    rsp_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.send_byte = rsp_if.send_byte;
      got.send_valid = rsp_if.send_valid;
      got.status = rsp_if.status;
      got.received_length = rsp_if.received_length;
      got.read_byte = rsp_if.read_byte;
      got.packet_ready = rsp_if.packet_ready;
      got.tx_busy = rsp_if.tx_busy;
      got.rx_busy = rsp_if.rx_busy;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: result beat %0d arrived with nothing expected: %s",
                   $time, results_seen, result_text(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: result beat %0d mismatch", $time, results_seen);
            $display("  expected %s", result_text(want));
            $display("  actual   %s", result_text(got));
          end
        end
      end
    end
  end

  task automatic test_tx_frame();
    send_item(ActTxBegin, 8'h00, 8'd1);
    send_item(ActTxPayload, 8'hFF, 8'h00);
    send_item(ActTxPayload, 8'h00, 8'h00);
    repeat (12) send_item(ActEvent, 8'h00, 8'h00);
  endtask

  task automatic test_rx_status();
    send_item(ActRxStart, 8'h00, 8'h00);
    send_item(ActRxStart, 8'h00, 8'h00);
    send_item(ActRxTake, 8'h00, 8'h00);
    send_item(ActEvent, 8'h00, 8'h00);
    send_item(ActEvent, 8'hFF, 8'hFF);
    send_item(ActEvent, 8'h80, 8'h00);
    send_item(ActRxStart, 8'h00, 8'h00);
    send_item(ActRxTake, 8'h00, 8'h00);
    send_item(ActRxTake, 8'h00, 8'h00);
    send_item(ActRxRead, 8'h00, 8'd0);
    send_item(ActRxRead, 8'h00, 8'd1);
    send_item(ActRxRead, 8'h00, 8'(MaxPay));
    send_item(ActRxRead, 8'h00, 8'hFF);
  endtask

  task automatic test_tx_rules();
    send_item(ActTxBegin, 8'h00, 8'(MaxPay + 1));
    send_item(ActTxPayload, 8'h5A, 8'h00);
    send_item(ActTxBegin, 8'h00, 8'd0);
    send_item(ActRxStart, 8'h00, 8'h00);
    send_item(ActTxPayload, 8'hA5, 8'h00);
    send_item(ActStop, 8'h00, 8'h00);
    send_item(ActUnused, 8'hFF, 8'hFF);
    send_item(ActEvent, 8'h33, 8'h00);
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    send_item(ActTxBegin, 8'h00, 8'd10);
    repeat (10) send_item(ActTxPayload, 8'($urandom), 8'h00);
    repeat (20) send_item(ActEvent, 8'h00, 8'h00);
  endtask

  task automatic random_traffic(input int n_beats, input int idle_pct, input int stall_pct);
    int target;
    int unsigned len;
    int unsigned evs;
    logic [7:0] head;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = ($urandom_range(7) == 0) ? $urandom_range(MaxPay - 8, MaxPay)
                                         : $urandom_range(8);
          send_item(ActTxBegin, 8'($urandom), 8'(len));
          repeat (len + $urandom_range(1)) send_item(ActTxPayload, 8'($urandom), 8'($urandom));
          repeat (len + 10 + $urandom_range(1)) send_item(ActEvent, 8'($urandom), 8'($urandom));
        end
        4, 5, 6, 7: begin
          send_item(ActRxStart, 8'($urandom), 8'($urandom));
          head = ($urandom_range(3) == 0) ? 8'($urandom_range(MaxPay - 2, 255))
                                          : 8'($urandom_range(12));
          len = (head > MaxPay) ? MaxPay : head;
          evs = (len + RxEndOffset <= MaxPay) ? len + RxEndOffset : MaxPay + 1;
          send_item(ActEvent, head, 8'($urandom));
          repeat (evs - 1) send_item(ActEvent, 8'($urandom), 8'($urandom));
          send_item(ActRxTake, 8'($urandom), 8'($urandom));
          repeat ($urandom_range(4))
            send_item(ActRxRead, 8'($urandom),
                      ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(len)));
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_item(3'($urandom), 8'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.data_byte = '0;
    req_if.count_or_position = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_tx_frame();
    test_rx_status();
    test_tx_rules();
    test_backpressure();
    random_traffic(210, 0, 0);
    random_traffic(210, 68, 0);
    random_traffic(210, 0, 68);
    random_traffic(210, 6, 6);

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** radio_packet_framer_top: PASSED **");
    end else begin
      $display("** radio_packet_framer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** radio_packet_framer_top: FAILED **");
    $finish;
  end

endmodule
